// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the serial command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int PAYLOAD_LEN_DEF = 33;
    localparam int MAX_CMD_LEN_DEF = 35;

    localparam int CNT_W   = 6;
    localparam int EV_W    = 3;
    localparam int NCELLS  = 5;

    // event codes
    localparam logic [EV_W-1:0] EV_RESET     = 3'd0;
    localparam logic [EV_W-1:0] EV_READ_PARA = 3'd1;
    localparam logic [EV_W-1:0] EV_READ_SENS = 3'd2;
    localparam logic [EV_W-1:0] EV_WRITE     = 3'd3;
    localparam logic [EV_W-1:0] EV_PAYLOAD   = 3'd4;

    // characters of interest
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_I    = 8'h69;

    // per-cell character decode
    typedef struct packed {
        logic is_r;
        logic is_e;
        logic is_s;
        logic is_t;
        logic is_c;
        logic is_i;
    } scp_hit_t;

endpackage

// ===== rtl/scp_cell.sv =====
// ----------------------------------------------------------------------------
// scp_cell
// One stage of the recent-byte history: holds a byte, passes it on when the
// chain shifts, and decodes it against the command characters.
// ----------------------------------------------------------------------------
module scp_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic [7:0]      byte_in,
    output logic [7:0]      byte_out,
    output scp_pkg::scp_hit_t hit
);
    import scp_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? byte_in : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    always_comb
    begin
        hit.is_r = (byte_reg == CH_R);
        hit.is_e = (byte_reg == CH_E);
        hit.is_s = (byte_reg == CH_S);
        hit.is_t = (byte_reg == CH_T);
        hit.is_c = (byte_reg == CH_C);
        hit.is_i = (byte_reg == CH_I);
    end

endmodule

// ===== rtl/serial_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// serial_command_parser_unit
// Parses serial command messages and forwards the parameter payload.
// ----------------------------------------------------------------------------
// One received byte is taken per beat, one beat per clock when the output
// side keeps up; each byte gives at most one output beat, which is registered
// and held in a single output register. Messages end in '!': "reset!", "cr!",
// "cs!" and "ci!" report events 0..3 on tuser, anything else is dropped,
// as is a message reaching MAX_CMD_LEN bytes without '!'. After "ci!" one
// byte is skipped and the next PAYLOAD_LEN bytes come out as event 4 with
// their index in tdata and tlast on the final one. The last five command
// bytes sit in a shift chain of five cells that decode their own byte.
// ----------------------------------------------------------------------------
module serial_command_parser_unit #(
    parameter int PAYLOAD_LEN = scp_pkg::PAYLOAD_LEN_DEF,
    parameter int MAX_CMD_LEN = scp_pkg::MAX_CMD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] payload_index, [13:6] payload_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    output logic        m_axis_tlast    // payload_last
);
    import scp_pkg::*;

    logic [7:0] rx_byte;
    logic       in_fire;

    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;

    logic             ov_reg,   ov_next;
    logic [EV_W-1:0]  ev_reg,   ev_next;
    logic [CNT_W-1:0] idx_reg,  idx_next;
    logic [7:0]       pb_reg,   pb_next;
    logic             last_reg, last_next;

    logic       shift_en;
    logic [7:0] chain [NCELLS+1];
    scp_hit_t   hit   [NCELLS];

    logic [CNT_W:0] cnt_inc;
    logic           is_bang;
    logic           m_reset, m_cmd;

    assign rx_byte       = s_axis_tdata;
    assign s_axis_tready = !ov_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // history chain, cell 0 holds the newest byte
    assign shift_en = in_fire && !mode_reg;
    assign chain[0] = rx_byte;

    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        scp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .byte_in  (chain[k]),
            .byte_out (chain[k+1]),
            .hit      (hit[k])
        );
    end

    assign cnt_inc = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign is_bang = (rx_byte == CH_BANG);
    assign m_reset = (cnt_reg >= CNT_W'(5)) && hit[4].is_r && hit[3].is_e &&
                     hit[2].is_s && hit[1].is_e && hit[0].is_t;
    assign m_cmd   = (cnt_reg >= CNT_W'(2)) && hit[1].is_c;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        ov_next   = ov_reg && !m_axis_tready;
        ev_next   = ev_reg;
        idx_next  = idx_reg;
        pb_next   = pb_reg;
        last_next = last_reg;

        if (in_fire)
        begin
            ev_next   = EV_PAYLOAD;
            idx_next  = '0;
            pb_next   = '0;
            last_next = 1'b0;
            if (mode_reg)
            begin
                cnt_next = cnt_inc[CNT_W-1:0];
                if (cnt_reg != '0)
                begin
                    ov_next  = 1'b1;
                    idx_next = cnt_reg - CNT_W'(1);
                    pb_next  = rx_byte;
                    if (cnt_reg >= CNT_W'(PAYLOAD_LEN))
                    begin
                        last_next = 1'b1;
                        mode_next = 1'b0;
                        cnt_next  = '0;
                    end
                end
            end
            else if (is_bang)
            begin
                cnt_next = '0;
                if (m_reset)
                begin
                    ov_next = 1'b1;
                    ev_next = EV_RESET;
                end
                else if (m_cmd && hit[0].is_r)
                begin
                    ov_next = 1'b1;
                    ev_next = EV_READ_PARA;
                end
                else if (m_cmd && hit[0].is_s)
                begin
                    ov_next = 1'b1;
                    ev_next = EV_READ_SENS;
                end
                else if (m_cmd && hit[0].is_i)
                begin
                    ov_next   = 1'b1;
                    ev_next   = EV_WRITE;
                    mode_next = 1'b1;
                end
            end
            else if (cnt_inc >= (CNT_W+1)'(MAX_CMD_LEN))
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg   <= ev_next;
        idx_reg  <= idx_next;
        pb_reg   <= pb_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = ev_reg;
    assign m_axis_tdata  = {2'b00, pb_reg, idx_reg};
    assign m_axis_tlast  = last_reg;

    // ------------------------------------------------------------------------
    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_PAYLOAD)
        else $error("tlast on a non-payload beat");

    a_cmd_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != EV_PAYLOAD) |-> m_axis_tdata == '0)
        else $error("command beat carries payload data");

    a_enter_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mode_reg) |-> ov_reg && (ev_reg == EV_WRITE))
        else $error("payload mode entered without write event");

    a_leave_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(mode_reg) |-> ov_reg && last_reg)
        else $error("payload mode left without last beat");

    a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
        !mode_reg |-> cnt_reg < CNT_W'(MAX_CMD_LEN))
        else $error("command length out of range");

endmodule

// ===== verif/tb_serial_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_serial_command_parser_unit
// Self-checking bench for the serial command parser.
// ----------------------------------------------------------------------------
// Byte beats go in on the slave stream. A behavioural parser, fed from the
// accepted beats, queues the events and payload beats that should come out,
// and every output beat is checked against the head of that queue. Directed
// tests cover each command, the payload block and the message length limit.
// They are followed by a long hold-off on the output side and by random
// message traffic, first with random idle cycles on both sides, then without.
// ----------------------------------------------------------------------------
module tb_serial_command_parser_unit;

    import scp_pkg::*;

    localparam int PAYLOAD_LEN  = PAYLOAD_LEN_DEF;
    localparam int MAX_CMD_LEN  = MAX_CMD_LEN_DEF;
    localparam int WATCHDOG_LIM = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SHOW_ERRS    = 10;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic [5:0]      idx;
        logic [7:0]      val;
        logic            last;
    } parse_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [5:0] payload_index, [13:6] payload_byte
    logic [2:0]  m_axis_tuser;     // [2:0] event_res
    logic        m_axis_tlast;     // payload_last

    // parser state mirrored by the bench
    logic              pl_mode = 1'b0;
    logic [CNT_W-1:0]  msg_cnt = '0;
    logic [7:0]        hist [NCELLS] = '{default: 8'h00};

    parse_res_t result_q [$];
    int         err_cnt     = 0;
    int         stall_cycles = 0;
    int         sent_cnt    = 0;
    bit         src_idle_en = 1'b1;
    bit         sink_idle_en = 1'b1;
    bit         hold_req    = 1'b0;

    serial_command_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // One received byte through the parser; returns 1 when it yields a beat.
    function automatic bit parse_byte(input logic [7:0] b, output parse_res_t r);
        int n;
        bit hit;
        r   = '0;
        hit = 1'b0;
        if (pl_mode) begin
            n       = msg_cnt;
            msg_cnt = CNT_W'(n + 1);
            if (n != 0) begin
                hit   = 1'b1;
                r.ev  = EV_PAYLOAD;
                r.idx = 6'(n - 1);
                r.val = b;
                if (n >= PAYLOAD_LEN) begin
                    pl_mode = 1'b0;
                    msg_cnt = '0;
                    r.last  = 1'b1;
                end
            end
            return hit;
        end
        if (b == CH_BANG) begin
            n       = msg_cnt;
            msg_cnt = '0;
            // only bytes of the current message may complete a pattern
            if (n >= 5 && hist[4] == CH_R && hist[3] == CH_E && hist[2] == CH_S
                && hist[1] == CH_E && hist[0] == CH_T) begin
                hit  = 1'b1;
                r.ev = EV_RESET;
            end
            else if (n >= 2 && hist[1] == CH_C) begin
                if (hist[0] == CH_R) begin
                    hit  = 1'b1;
                    r.ev = EV_READ_PARA;
                end
                else if (hist[0] == CH_S) begin
                    hit  = 1'b1;
                    r.ev = EV_READ_SENS;
                end
                else if (hist[0] == CH_I) begin
                    hit     = 1'b1;
                    r.ev    = EV_WRITE;
                    pl_mode = 1'b1;
                end
            end
        end
        else if (int'(msg_cnt) + 1 >= MAX_CMD_LEN) begin
            msg_cnt = '0;
        end
        else begin
            msg_cnt = msg_cnt + 1'b1;
        end
        for (int i = NCELLS - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = b;
        return hit;
    endfunction

    // Output check, input prediction and watchdog, all on the rising edge.
    always @(posedge clk) begin : monitor
        parse_res_t want;
        parse_res_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{ev: m_axis_tuser, idx: m_axis_tdata[5:0],
                        val: m_axis_tdata[13:6], last: m_axis_tlast};
                if (result_q.size() == 0) begin
                    if (err_cnt < SHOW_ERRS)
                        $display("ERROR @%0t: unexpected beat ev=%0d idx=%0d byte=%02h last=%0b",
                                 $time, got.ev, got.idx, got.val, got.last);
                    err_cnt++;
                end
                else begin
                    want = result_q.pop_front();
                    if (got !== want || m_axis_tdata[15:14] !== 2'b00) begin
                        if (err_cnt < SHOW_ERRS) begin
                            $write("ERROR @%0t: exp ev=%0d idx=%0d byte=%02h last=%0b,",
                                   $time, want.ev, want.idx, want.val, want.last);
                            $display(" got ev=%0d idx=%0d byte=%02h last=%0b pad=%b",
                                     got.ev, got.idx, got.val, got.last,
                                     m_axis_tdata[15:14]);
                        end
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_byte(s_axis_tdata, want))
                    result_q.push_back(want);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIM) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIM);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Output side: random short stalls, plus one long hold when asked.
    initial begin : sink
        int burst;
        int hold_left;
        burst         = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One byte beat; tvalid stays up into the next call unless a gap is drawn.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        sent_cnt++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Any byte but '!', often one of the command letters.
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        string letters;
        letters = "rescti";
        if ($urandom_range(0, 2) == 0)
            return letters[$urandom_range(0, 5)];
        do b = 8'($urandom); while (b == CH_BANG);
        return b;
    endfunction

    // Drop tvalid and hold off until every predicted beat has come out.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
    endtask

    // One random message, mostly well formed.
    task automatic gen_message();
        int kind;
        int k;
        string pat;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            repeat ($urandom_range(0, 3)) send_byte(junk_byte());
            case ($urandom_range(0, 2))
                0:       send_text("reset!");
                1:       send_text("cr!");
                default: send_text("cs!");
            endcase
        end
        else if (kind < 55) begin
            send_text("ci!");
            repeat (PAYLOAD_LEN + 1) send_byte(8'($urandom));
        end
        else if (kind < 70) begin
            repeat ($urandom_range(0, 5)) send_byte(junk_byte());
            send_byte(CH_BANG);
        end
        else if (kind < 78) begin
            // too long: dropped, then a fresh command
            repeat ($urandom_range(MAX_CMD_LEN, MAX_CMD_LEN + 5)) send_byte(junk_byte());
            send_text("cr!");
        end
        else if (kind < 88) begin
            // length limit falls inside the pattern, so it must not match
            case ($urandom_range(0, 3))
                0:       pat = "reset";
                1:       pat = "cr";
                2:       pat = "cs";
                default: pat = "ci";
            endcase
            k = $urandom_range(1, pat.len() - 1);
            repeat (MAX_CMD_LEN - k) send_byte(junk_byte());
            send_text(pat);
            send_byte(CH_BANG);
        end
        else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end
    endtask

    task automatic test_commands();
        send_text("reset!");
        send_text("cr!");
        send_text("cs!");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BANG);
        send_text("xcr!");
        send_text("!");
        wait_drained();
    endtask

    task automatic test_payload();
        send_text("ci!");
        send_byte(CH_BANG);          // lead byte, swallowed
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BANG);
        repeat (PAYLOAD_LEN - 3) send_byte(8'($urandom));
        send_text("cs!");
        wait_drained();
    endtask

    task automatic test_message_limits();
        repeat (MAX_CMD_LEN - 1) send_byte(junk_byte());
        send_text("cr!");            // "c" ends the long message
        repeat (MAX_CMD_LEN + 2) send_byte(junk_byte());
        send_text("cs!");
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req    = 1'b1;
        src_idle_en = 1'b0;
        send_text("ci!");
        repeat (PAYLOAD_LEN + 1) send_byte(8'($urandom));
        wait_drained();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random(input int upto);
        while (sent_cnt < upto)
            gen_message();
        wait_drained();
    endtask

    task automatic test_tail(input int upto);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (sent_cnt < upto)
            gen_message();
        wait_drained();
    endtask

    initial begin : main
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_payload();
        test_message_limits();
        test_backpressure();
        test_random(420);
        test_tail(sent_cnt + 80);

        repeat (8) @(posedge clk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("simulation ok");
        end
        else begin
            if (result_q.size() != 0)
                $display("%0d expected beats never arrived", result_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
